FILE: rtl/gthrbt_pkg.sv
// ----------------------------------------------------------------------------
// gthrbt_pkg
// Types and constants for the guest-to-host register binding table.
// ----------------------------------------------------------------------------
package gthrbt_pkg;

    localparam int NUM_GUEST  = 32;
    localparam int NUM_HOST   = 16;
    localparam int GIDX_W     = $clog2(NUM_GUEST);
    localparam int HIDX_W     = $clog2(NUM_HOST);
    localparam int ORDER_MAX  = 16;
    localparam int ORDER_W    = ORDER_MAX * HIDX_W;
    localparam int OLEN_W     = 5;
    localparam int IMM_W      = 32;

    localparam logic [OLEN_W-1:0] OLEN_RESET = OLEN_W'(9);
    localparam logic [OLEN_W-1:0] OLEN_MAX   = OLEN_W'(ORDER_MAX);

    // configuration register indexes
    localparam logic CFG_ALLOC_ORDER = 1'b0;
    localparam logic CFG_ORDER_LEN   = 1'b1;

    typedef enum logic [3:0] {
        OP_START      = 4'd0,
        OP_LOCK_GUEST = 4'd1,
        OP_LOCK_HOST  = 4'd2,
        OP_UNLOCK_G   = 4'd3,
        OP_UNLOCK_H   = 4'd4,
        OP_BIND       = 4'd5,
        OP_STORE      = 4'd6,
        OP_FLUSH_HOST = 4'd7,
        OP_DISCARD    = 4'd8,
        OP_SET_IMM    = 4'd9,
        OP_KILL_IMM   = 4'd10,
        OP_FLUSH_ALL  = 4'd11,
        OP_SAVE       = 4'd12,
        OP_RESTORE    = 4'd13
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HOST   = 2'd1;
    localparam logic [1:0] ST_HOST_LOCK = 2'd2;
    localparam logic [1:0] ST_LOCK_HELD = 2'd3;

    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_HOME = 2'd1;
    localparam logic [1:0] LD_IMM  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN1,
        S_SCAN2,
        S_EVICT,
        S_FINAL,
        S_FLUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              away;
        logic              is_imm;
        logic [HIDX_W-1:0] host;
        logic [IMM_W-1:0]  imm;
    } gslot_t;

    typedef struct packed {
        logic              free;
        logic              dirty;
        logic [GIDX_W-1:0] owner;
    } hslot_t;

    typedef struct packed {
        logic [3:0]        operation;
        logic [GIDX_W-1:0] guest_reg;
        logic [HIDX_W-1:0] host_reg_in;
        logic [IMM_W-1:0]  imm_value;
        logic              do_load;
        logic              make_dirty;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [HIDX_W-1:0] host_reg_out;
        logic [1:0]        load_kind;
        logic              store_valid;
        logic [GIDX_W-1:0] store_guest;
        logic              store_from_imm;
        logic [HIDX_W-1:0] store_host;
        logic [IMM_W-1:0]  value_out;
        logic              last;
    } rsp_t;

    localparam gslot_t GSLOT_HOME = '{away: 1'b0, is_imm: 1'b0, host: '0, imm: '0};
    localparam hslot_t HSLOT_FREE = '{free: 1'b1, dirty: 1'b0, owner: '0};

endpackage

FILE: rtl/guest_to_host_register_binding_table.sv
// ----------------------------------------------------------------------------
// guest_to_host_register_binding_table
// Binding table of guest registers to home, immediate or host registers.
// ----------------------------------------------------------------------------
// Sequence: simple operations decode, then issue the result; bind at most decodes,
//   runs the first-free scan then the eviction scan one order entry per cycle
//   plus an end check each, then evicts, allocates and issues the result.
// Flush all: decode, 32 guest entries (held while a store result stalls), closing result.
// Throughput: one request at a time; next request taken after result issued.
// Reset: all guests at home, hosts free and clean, locks clear, order length 9.
// ----------------------------------------------------------------------------
module guest_to_host_register_binding_table
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [gthrbt_pkg::ORDER_W-1:0]       cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  gthrbt_pkg::req_t                     req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output gthrbt_pkg::rsp_t                     rsp
);

    gthrbt_pkg::state_t state_reg, state_next;
    gthrbt_pkg::req_t   req_reg, req_next;
    gthrbt_pkg::rsp_t   res_reg, res_next;
    gthrbt_pkg::rsp_t   out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic [gthrbt_pkg::GIDX_W-1:0] idx_reg, idx_next;
    logic [gthrbt_pkg::HIDX_W-1:0] hsel_reg, hsel_next;

    logic [gthrbt_pkg::ORDER_W-1:0] order_reg;
    logic [gthrbt_pkg::OLEN_W-1:0]  olen_reg;

    gthrbt_pkg::gslot_t gb_reg [gthrbt_pkg::NUM_GUEST];
    gthrbt_pkg::gslot_t gb_next [gthrbt_pkg::NUM_GUEST];
    gthrbt_pkg::hslot_t hb_reg [gthrbt_pkg::NUM_HOST];
    gthrbt_pkg::hslot_t hb_next [gthrbt_pkg::NUM_HOST];
    gthrbt_pkg::gslot_t sgb_reg [gthrbt_pkg::NUM_GUEST];
    gthrbt_pkg::gslot_t sgb_next [gthrbt_pkg::NUM_GUEST];
    gthrbt_pkg::hslot_t shb_reg [gthrbt_pkg::NUM_HOST];
    gthrbt_pkg::hslot_t shb_next [gthrbt_pkg::NUM_HOST];
    logic [gthrbt_pkg::NUM_GUEST-1:0] glock_reg, glock_next, sglock_reg, sglock_next;
    logic [gthrbt_pkg::NUM_HOST-1:0]  hlock_reg, hlock_next, shlock_reg, shlock_next;

    logic                           emit_ok;
    logic                           emit;
    gthrbt_pkg::rsp_t               emit_data;
    logic [gthrbt_pkg::OLEN_W-1:0]  len;
    logic [gthrbt_pkg::HIDX_W-1:0]  x;
    logic                           scan_end;
    logic [gthrbt_pkg::GIDX_W-1:0]  gidx;
    gthrbt_pkg::gslot_t             grd;
    logic                           sb_st;
    logic                           was_imm;
    logic [gthrbt_pkg::HIDX_W-1:0]  gh;

    assign req_stall = (state_reg != gthrbt_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign emit_ok   = !out_valid_reg || !rsp_stall;

    assign len      = (olen_reg > gthrbt_pkg::OLEN_MAX) ? gthrbt_pkg::OLEN_MAX : olen_reg;
    assign x        = order_reg[idx_reg[gthrbt_pkg::HIDX_W-1:0]*gthrbt_pkg::HIDX_W +:
                                gthrbt_pkg::HIDX_W];
    assign scan_end = ({1'b0, idx_reg} >= {1'b0, len});

    // single read port on the guest table
    always_comb
    begin
        case (state_reg)
            gthrbt_pkg::S_EVICT: gidx = hb_reg[hsel_reg].owner;
            gthrbt_pkg::S_FLUSH: gidx = idx_reg;
            default:
            begin
                if (req_reg.operation == gthrbt_pkg::OP_FLUSH_HOST)
                    gidx = hb_reg[req_reg.host_reg_in].owner;
                else
                    gidx = req_reg.guest_reg;
            end
        endcase
    end

    assign grd     = gb_reg[gidx];
    assign gh      = grd.host;
    assign sb_st   = grd.away && (grd.is_imm || hb_reg[gh].dirty);
    assign was_imm = grd.away && grd.is_imm;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        idx_next    = idx_reg;
        hsel_next   = hsel_reg;
        gb_next     = gb_reg;
        hb_next     = hb_reg;
        sgb_next    = sgb_reg;
        shb_next    = shb_reg;
        glock_next  = glock_reg;
        hlock_next  = hlock_reg;
        sglock_next = sglock_reg;
        shlock_next = shlock_reg;
        emit        = 1'b0;
        emit_data   = res_reg;

        case (state_reg)
            gthrbt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = gthrbt_pkg::S_EXEC;
                end
            end

            gthrbt_pkg::S_EXEC:
            begin
                state_next = gthrbt_pkg::S_DONE;
                case (req_reg.operation)
                    gthrbt_pkg::OP_START:
                    begin
                        for (int i = 0; i < gthrbt_pkg::NUM_HOST; i++)
                        begin
                            hb_next[i].free  = 1'b1;
                            hb_next[i].dirty = 1'b0;
                        end
                        for (int i = 0; i < gthrbt_pkg::NUM_GUEST; i++)
                            gb_next[i] = gthrbt_pkg::GSLOT_HOME;
                        hlock_next = '0;
                    end
                    gthrbt_pkg::OP_LOCK_GUEST: glock_next[req_reg.guest_reg] = 1'b1;
                    gthrbt_pkg::OP_LOCK_HOST:
                    begin
                        if (hlock_reg[req_reg.host_reg_in])
                            res_next.status = gthrbt_pkg::ST_HOST_LOCK;
                        hlock_next[req_reg.host_reg_in] = 1'b1;
                    end
                    gthrbt_pkg::OP_UNLOCK_G: glock_next = '0;
                    gthrbt_pkg::OP_UNLOCK_H: hlock_next = '0;
                    gthrbt_pkg::OP_BIND, gthrbt_pkg::OP_KILL_IMM:
                    begin
                        if (grd.away && !grd.is_imm)
                        begin
                            hb_next[gh].dirty = hb_reg[gh].dirty || req_reg.make_dirty;
                            res_next.host_reg_out = gh;
                            if (hlock_reg[gh] && req_reg.operation == gthrbt_pkg::OP_BIND)
                                res_next.status = gthrbt_pkg::ST_HOST_LOCK;
                        end
                        else if (grd.away || req_reg.operation == gthrbt_pkg::OP_BIND)
                        begin
                            idx_next   = '0;
                            state_next = gthrbt_pkg::S_SCAN1;
                        end
                    end
                    gthrbt_pkg::OP_STORE, gthrbt_pkg::OP_FLUSH_HOST:
                    begin
                        if (req_reg.operation == gthrbt_pkg::OP_STORE ||
                            !hb_reg[req_reg.host_reg_in].free)
                        begin
                            if (grd.away)
                            begin
                                if (!grd.is_imm)
                                    hb_next[gh] = gthrbt_pkg::HSLOT_FREE;
                                gb_next[gidx] = gthrbt_pkg::GSLOT_HOME;
                            end
                            if (sb_st)
                            begin
                                res_next.store_valid    = 1'b1;
                                res_next.store_guest    = gidx;
                                res_next.store_from_imm = grd.is_imm;
                                res_next.store_host     = grd.is_imm ? '0 : gh;
                                res_next.value_out      = grd.is_imm ? grd.imm : '0;
                            end
                        end
                    end
                    gthrbt_pkg::OP_DISCARD, gthrbt_pkg::OP_SET_IMM:
                    begin
                        if (grd.away && !grd.is_imm)
                        begin
                            hb_next[gh]   = gthrbt_pkg::HSLOT_FREE;
                            gb_next[gidx] = gthrbt_pkg::GSLOT_HOME;
                        end
                        if (req_reg.operation == gthrbt_pkg::OP_SET_IMM)
                            gb_next[gidx] = '{away: 1'b1, is_imm: 1'b1, host: '0,
                                              imm: req_reg.imm_value};
                    end
                    gthrbt_pkg::OP_FLUSH_ALL:
                    begin
                        if (glock_reg != '0 || hlock_reg != '0)
                            res_next.status = gthrbt_pkg::ST_LOCK_HELD;
                        idx_next   = '0;
                        state_next = gthrbt_pkg::S_FLUSH;
                    end
                    gthrbt_pkg::OP_SAVE:
                    begin
                        sgb_next    = gb_reg;
                        shb_next    = hb_reg;
                        sglock_next = glock_reg;
                        shlock_next = hlock_reg;
                    end
                    gthrbt_pkg::OP_RESTORE:
                    begin
                        gb_next    = sgb_reg;
                        hb_next    = shb_reg;
                        glock_next = sglock_reg;
                        hlock_next = shlock_reg;
                    end
                    default: ;
                endcase
            end

            // first free, unlocked host in allocation order
            gthrbt_pkg::S_SCAN1:
            begin
                if (scan_end)
                begin
                    idx_next   = '0;
                    state_next = gthrbt_pkg::S_SCAN2;
                end
                else if (!hlock_reg[x] && hb_reg[x].free)
                begin
                    hsel_next  = x;
                    state_next = gthrbt_pkg::S_FINAL;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            // first unlocked host whose owner is unlocked
            gthrbt_pkg::S_SCAN2:
            begin
                if (scan_end)
                begin
                    res_next.status = gthrbt_pkg::ST_NO_HOST;
                    state_next      = gthrbt_pkg::S_DONE;
                end
                else if (!hlock_reg[x] && !glock_reg[hb_reg[x].owner])
                begin
                    hsel_next  = x;
                    state_next = gthrbt_pkg::S_EVICT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            gthrbt_pkg::S_EVICT:
            begin
                if (grd.away)
                begin
                    if (!grd.is_imm)
                        hb_next[gh] = gthrbt_pkg::HSLOT_FREE;
                    gb_next[gidx] = gthrbt_pkg::GSLOT_HOME;
                end
                if (sb_st)
                begin
                    res_next.store_valid    = 1'b1;
                    res_next.store_guest    = gidx;
                    res_next.store_from_imm = grd.is_imm;
                    res_next.store_host     = grd.is_imm ? '0 : gh;
                    res_next.value_out      = grd.is_imm ? grd.imm : '0;
                end
                state_next = gthrbt_pkg::S_FINAL;
            end

            gthrbt_pkg::S_FINAL:
            begin
                hb_next[hsel_reg] = '{free: 1'b0, dirty: req_reg.make_dirty || was_imm,
                                      owner: gidx};
                if (req_reg.do_load)
                begin
                    res_next.load_kind = was_imm ? gthrbt_pkg::LD_IMM : gthrbt_pkg::LD_HOME;
                    if (was_imm)
                        res_next.value_out = grd.imm;
                end
                gb_next[gidx] = '{away: 1'b1, is_imm: 1'b0, host: hsel_reg, imm: '0};
                res_next.host_reg_out = hsel_reg;
                state_next = gthrbt_pkg::S_DONE;
            end

            gthrbt_pkg::S_FLUSH:
            begin
                if (!sb_st || emit_ok)
                begin
                    if (grd.away)
                    begin
                        if (!grd.is_imm)
                            hb_next[gh] = gthrbt_pkg::HSLOT_FREE;
                        gb_next[gidx] = gthrbt_pkg::GSLOT_HOME;
                    end
                    if (sb_st)
                    begin
                        emit      = 1'b1;
                        emit_data = '0;
                        emit_data.store_valid    = 1'b1;
                        emit_data.store_guest    = gidx;
                        emit_data.store_from_imm = grd.is_imm;
                        emit_data.store_host     = grd.is_imm ? '0 : gh;
                        emit_data.value_out      = grd.is_imm ? grd.imm : '0;
                    end
                    if (idx_reg == gthrbt_pkg::GIDX_W'(gthrbt_pkg::NUM_GUEST - 1))
                        state_next = gthrbt_pkg::S_DONE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end

            gthrbt_pkg::S_DONE:
            begin
                if (emit_ok)
                begin
                    emit           = 1'b1;
                    emit_data      = res_reg;
                    emit_data.last = 1'b1;
                    state_next     = gthrbt_pkg::S_IDLE;
                end
            end

            default: state_next = gthrbt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gthrbt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            order_reg     <= '0;
            olen_reg      <= gthrbt_pkg::OLEN_RESET;
            glock_reg     <= '0;
            hlock_reg     <= '0;
            sglock_reg    <= '0;
            shlock_reg    <= '0;
            for (int i = 0; i < gthrbt_pkg::NUM_GUEST; i++)
            begin
                gb_reg[i]  <= gthrbt_pkg::GSLOT_HOME;
                sgb_reg[i] <= gthrbt_pkg::GSLOT_HOME;
            end
            for (int i = 0; i < gthrbt_pkg::NUM_HOST; i++)
            begin
                hb_reg[i]  <= gthrbt_pkg::HSLOT_FREE;
                shb_reg[i] <= gthrbt_pkg::HSLOT_FREE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            glock_reg     <= glock_next;
            hlock_reg     <= hlock_next;
            sglock_reg    <= sglock_next;
            shlock_reg    <= shlock_next;
            gb_reg        <= gb_next;
            hb_reg        <= hb_next;
            sgb_reg       <= sgb_next;
            shb_reg       <= shb_next;
            if (cfg_we)
            begin
                if (cfg_index == gthrbt_pkg::CFG_ALLOC_ORDER)
                    order_reg <= cfg_data;
                else
                    olen_reg <= cfg_data[gthrbt_pkg::OLEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        idx_reg  <= idx_next;
        hsel_reg <= hsel_next;
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_valid_reg) |-> !rsp_stall)
        else $error("result register overwritten while stalled");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gthrbt_pkg::S_DONE && emit) |=> state_reg == gthrbt_pkg::S_IDLE)
        else $error("sequencer did not return to idle after final result");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gthrbt_pkg::S_SCAN1 || state_reg == gthrbt_pkg::S_SCAN2)
        |-> idx_reg <= gthrbt_pkg::GIDX_W'(gthrbt_pkg::ORDER_MAX))
        else $error("allocation scan ran past the order");

    a_nonlast_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !emit_data.last) |-> state_reg == gthrbt_pkg::S_FLUSH)
        else $error("intermediate result outside flush walk");
`endif

endmodule

FILE: sim/guest_to_host_register_binding_table_tb.sv
// ----------------------------------------------------------------------------
// guest_to_host_register_binding_table_tb
// Drives a directed table of requests and then random phases under several
// allocation orders and order lengths. Every response is compared field by
// field with a bench copy of the binding table or a fixed directed result.
// ----------------------------------------------------------------------------
module guest_to_host_register_binding_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 80;
    localparam int PHASES     = 6;
    localparam int PER_PHASE  = 45;

    typedef struct {
        gthrbt_pkg::req_t rq;
        bit               typed;
        gthrbt_pkg::rsp_t want;
    } vec_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic                             cfg_index;
    logic [gthrbt_pkg::ORDER_W-1:0]   cfg_data;
    logic                             req_valid;
    logic                             req_stall;
    gthrbt_pkg::req_t                 req;
    logic                             rsp_valid;
    logic                             rsp_stall;
    gthrbt_pkg::rsp_t                 rsp;

    // bench copy of the table
    gthrbt_pkg::gslot_t               gb [gthrbt_pkg::NUM_GUEST];
    gthrbt_pkg::hslot_t               hb [gthrbt_pkg::NUM_HOST];
    gthrbt_pkg::gslot_t               sgb [gthrbt_pkg::NUM_GUEST];
    gthrbt_pkg::hslot_t               shb [gthrbt_pkg::NUM_HOST];
    logic [gthrbt_pkg::NUM_GUEST-1:0] glk, sglk;
    logic [gthrbt_pkg::NUM_HOST-1:0]  hlk, shlk;
    logic [gthrbt_pkg::ORDER_W-1:0]   order;
    logic [gthrbt_pkg::OLEN_W-1:0]    olen;

    gthrbt_pkg::rsp_t                 step_results [$];
    gthrbt_pkg::rsp_t                 pending_rsp [$];
    vec_t                             dir_tab [$];
    int                               errors;
    int                               idle_cycles;
    int                               send_idle_pct;
    int                               stall_pct;

    guest_to_host_register_binding_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------
    function automatic bit write_home(int g, inout gthrbt_pkg::rsp_t r);
        bit st;
        int h;
        st = 1'b0;
        if (!gb[g].away)
            return 1'b0;
        if (gb[g].is_imm)
        begin
            st = 1'b1;
            r.store_from_imm = 1'b1;
            r.value_out = gb[g].imm;
        end
        else
        begin
            h = gb[g].host;
            st = hb[h].dirty;
            hb[h] = gthrbt_pkg::HSLOT_FREE;
            if (st)
                r.store_host = gthrbt_pkg::HIDX_W'(h);
        end
        if (st)
        begin
            r.store_valid = 1'b1;
            r.store_guest = gthrbt_pkg::GIDX_W'(g);
        end
        gb[g] = gthrbt_pkg::GSLOT_HOME;
        return st;
    endfunction

    function automatic void drop_guest(int g);
        if (gb[g].away && !gb[g].is_imm)
        begin
            hb[gb[g].host] = gthrbt_pkg::HSLOT_FREE;
            gb[g] = gthrbt_pkg::GSLOT_HOME;
        end
    endfunction

    function automatic void bind_guest(int g, bit dl, bit md, inout gthrbt_pkg::rsp_t r);
        int len, i, h, x, o;
        bit found, was_imm;
        len = (olen > 16) ? 16 : olen;
        found = 1'b0;
        h = 0;
        if (gb[g].away && !gb[g].is_imm)
        begin
            h = gb[g].host;
            hb[h].dirty = hb[h].dirty | md;
            r.host_reg_out = gthrbt_pkg::HIDX_W'(h);
            if (hlk[h])
                r.status = gthrbt_pkg::ST_HOST_LOCK;
            return;
        end
        for (i = 0; i < len && !found; i++)
        begin
            x = order[4*i +: 4];
            if (!hlk[x] && hb[x].free)
            begin
                h = x;
                found = 1'b1;
            end
        end
        // nothing free: evict first unlocked victim whose owner is unlocked
        for (i = 0; i < len && !found; i++)
        begin
            x = order[4*i +: 4];
            o = hb[x].owner;
            if (!hlk[x] && !glk[o])
            begin
                void'(write_home(o, r));
                h = x;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            r.status = gthrbt_pkg::ST_NO_HOST;
            return;
        end
        was_imm = gb[g].away && gb[g].is_imm;
        hb[h].free = 1'b0;
        hb[h].owner = gthrbt_pkg::GIDX_W'(g);
        hb[h].dirty = md | was_imm;
        if (dl)
        begin
            r.load_kind = was_imm ? gthrbt_pkg::LD_IMM : gthrbt_pkg::LD_HOME;
            if (was_imm)
                r.value_out = gb[g].imm;
        end
        gb[g] = '{away: 1'b1, is_imm: 1'b0, host: gthrbt_pkg::HIDX_W'(h), imm: '0};
        r.host_reg_out = gthrbt_pkg::HIDX_W'(h);
    endfunction

    function automatic void predict_step(gthrbt_pkg::req_t q);
        gthrbt_pkg::rsp_t r, s;
        int g, h;
        r = '0;
        g = q.guest_reg;
        h = q.host_reg_in;
        step_results.delete();
        case (q.operation)
            gthrbt_pkg::OP_START:
            begin
                for (int i = 0; i < gthrbt_pkg::NUM_HOST; i++)
                begin
                    hb[i].free = 1'b1;
                    hb[i].dirty = 1'b0;
                end
                hlk = '0;
                for (int i = 0; i < gthrbt_pkg::NUM_GUEST; i++)
                    gb[i] = gthrbt_pkg::GSLOT_HOME;
            end
            gthrbt_pkg::OP_LOCK_GUEST: glk[g] = 1'b1;
            gthrbt_pkg::OP_LOCK_HOST:
            begin
                if (hlk[h])
                    r.status = gthrbt_pkg::ST_HOST_LOCK;
                hlk[h] = 1'b1;
            end
            gthrbt_pkg::OP_UNLOCK_G:   glk = '0;
            gthrbt_pkg::OP_UNLOCK_H:   hlk = '0;
            gthrbt_pkg::OP_BIND:       bind_guest(g, q.do_load, q.make_dirty, r);
            gthrbt_pkg::OP_STORE:      void'(write_home(g, r));
            gthrbt_pkg::OP_FLUSH_HOST:
                if (!hb[h].free)
                    void'(write_home(hb[h].owner, r));
            gthrbt_pkg::OP_DISCARD:    drop_guest(g);
            gthrbt_pkg::OP_SET_IMM:
            begin
                drop_guest(g);
                gb[g] = '{away: 1'b1, is_imm: 1'b1, host: '0, imm: q.imm_value};
            end
            gthrbt_pkg::OP_KILL_IMM:
                if (gb[g].away)
                begin
                    if (gb[g].is_imm)
                        bind_guest(g, q.do_load, q.make_dirty, r);
                    else
                    begin
                        hb[gb[g].host].dirty = hb[gb[g].host].dirty | q.make_dirty;
                        r.host_reg_out = gb[g].host;
                    end
                end
            gthrbt_pkg::OP_FLUSH_ALL:
            begin
                if (glk != '0 || hlk != '0)
                    r.status = gthrbt_pkg::ST_LOCK_HELD;
                for (int i = 0; i < gthrbt_pkg::NUM_GUEST; i++)
                begin
                    s = '0;
                    if (write_home(i, s))
                        step_results.push_back(s);
                end
            end
            gthrbt_pkg::OP_SAVE:
            begin
                sgb = gb;
                shb = hb;
                sglk = glk;
                shlk = hlk;
            end
            gthrbt_pkg::OP_RESTORE:
            begin
                gb = sgb;
                hb = shb;
                glk = sglk;
                hlk = shlk;
            end
            default: ;
        endcase
        r.last = 1'b1;
        step_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        gthrbt_pkg::rsp_t w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report("unexpected response", 64'(rsp), 0);
            else
            begin
                w = pending_rsp.pop_front();
                if (rsp.status !== w.status)
                    report("status", rsp.status, w.status);
                if (rsp.host_reg_out !== w.host_reg_out)
                    report("host_reg_out", rsp.host_reg_out, w.host_reg_out);
                if (rsp.load_kind !== w.load_kind)
                    report("load_kind", rsp.load_kind, w.load_kind);
                if (rsp.store_valid !== w.store_valid)
                    report("store_valid", rsp.store_valid, w.store_valid);
                if (rsp.store_guest !== w.store_guest)
                    report("store_guest", rsp.store_guest, w.store_guest);
                if (rsp.store_from_imm !== w.store_from_imm)
                    report("store_from_imm", rsp.store_from_imm, w.store_from_imm);
                if (rsp.store_host !== w.store_host)
                    report("store_host", rsp.store_host, w.store_host);
                if (rsp.value_out !== w.value_out)
                    report("value_out", rsp.value_out, w.value_out);
                if (rsp.last !== w.last)
                    report("last", rsp.last, w.last);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // hang detection: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic gthrbt_pkg::req_t mk(gthrbt_pkg::op_t op, int g, int h,
                                            logic [31:0] imm, bit dl, bit md);
        gthrbt_pkg::req_t q;
        q.operation = op;
        q.guest_reg = gthrbt_pkg::GIDX_W'(g);
        q.host_reg_in = gthrbt_pkg::HIDX_W'(h);
        q.imm_value = imm;
        q.do_load = dl;
        q.make_dirty = md;
        return q;
    endfunction

    function automatic gthrbt_pkg::rsp_t closing(logic [1:0] st);
        gthrbt_pkg::rsp_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add(gthrbt_pkg::req_t q, bit typed = 1'b0,
                                gthrbt_pkg::rsp_t want = '0);
        dir_tab.push_back('{rq: q, typed: typed, want: want});
    endfunction

    function automatic gthrbt_pkg::req_t rand_req();
        gthrbt_pkg::req_t q;
        int               p;
        gthrbt_pkg::op_t  op;
        logic [63:0]      rnd;
        rnd = {$urandom, $urandom};
        q = gthrbt_pkg::req_t'(rnd[$bits(gthrbt_pkg::req_t)-1:0]);
        p = $urandom_range(99);
        if (p < 30)      op = gthrbt_pkg::OP_BIND;
        else if (p < 42) op = gthrbt_pkg::OP_SET_IMM;
        else if (p < 52) op = gthrbt_pkg::OP_KILL_IMM;
        else if (p < 60) op = gthrbt_pkg::OP_STORE;
        else if (p < 66) op = gthrbt_pkg::OP_FLUSH_HOST;
        else if (p < 72) op = gthrbt_pkg::OP_DISCARD;
        else if (p < 76) op = gthrbt_pkg::OP_LOCK_GUEST;
        else if (p < 80) op = gthrbt_pkg::OP_UNLOCK_G;
        else if (p < 84) op = gthrbt_pkg::OP_LOCK_HOST;
        else if (p < 88) op = gthrbt_pkg::OP_UNLOCK_H;
        else if (p < 92) op = gthrbt_pkg::OP_FLUSH_ALL;
        else if (p < 95) op = gthrbt_pkg::OP_SAVE;
        else if (p < 98) op = gthrbt_pkg::OP_RESTORE;
        else             op = gthrbt_pkg::OP_START;
        q.operation = op;
        if ($urandom_range(99) == 0)
            q.operation = 4'($urandom_range(15, 14));
        // mostly a small working set so binds collide and evict
        if ($urandom_range(9) < 7)
            q.guest_reg = gthrbt_pkg::GIDX_W'($urandom_range(7));
        case ($urandom_range(9))
            0: q.imm_value = '0;
            1: q.imm_value = '1;
            default: ;
        endcase
        return q;
    endfunction

    task automatic send(gthrbt_pkg::req_t q, bit typed = 1'b0,
                        gthrbt_pkg::rsp_t want = '0);
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_step(q);
        if (typed)
            pending_rsp.push_back(want);
        else
            foreach (step_results[i])
                pending_rsp.push_back(step_results[i]);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [gthrbt_pkg::ORDER_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gthrbt_pkg::CFG_ALLOC_ORDER)
            order = d;
        else
            olen = d[gthrbt_pkg::OLEN_W-1:0];
    endtask

    initial
    begin
        logic [gthrbt_pkg::ORDER_W-1:0] ord_set [PHASES];
        int                             len_set [PHASES];

        errors = 0;
        send_idle_pct = 33;
        stall_pct = 52;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data <= '0;
        req_valid <= 1'b0;
        req <= '0;
        for (int i = 0; i < gthrbt_pkg::NUM_GUEST; i++)
            gb[i] = gthrbt_pkg::GSLOT_HOME;
        for (int i = 0; i < gthrbt_pkg::NUM_HOST; i++)
            hb[i] = gthrbt_pkg::HSLOT_FREE;
        sgb = gb;
        shb = hb;
        glk = '0;
        hlk = '0;
        sglk = '0;
        shlk = '0;
        order = '0;
        olen = gthrbt_pkg::OLEN_RESET;

        // directed part runs with the reset order: every entry host 0
        add(mk(gthrbt_pkg::OP_FLUSH_ALL, 0, 0, 0, 0, 0), 1'b1, closing(gthrbt_pkg::ST_OK));
        add(mk(gthrbt_pkg::OP_LOCK_HOST, 0, 15, 0, 0, 0), 1'b1, closing(gthrbt_pkg::ST_OK));
        add(mk(gthrbt_pkg::OP_LOCK_HOST, 0, 15, 0, 0, 0), 1'b1,
            closing(gthrbt_pkg::ST_HOST_LOCK));
        add(mk(gthrbt_pkg::OP_FLUSH_ALL, 0, 0, 0, 0, 0), 1'b1,
            closing(gthrbt_pkg::ST_LOCK_HELD));
        add(mk(gthrbt_pkg::OP_UNLOCK_H, 0, 0, 0, 0, 0), 1'b1, closing(gthrbt_pkg::ST_OK));
        add(mk(gthrbt_pkg::OP_SET_IMM, 5, 0, 32'hFFFF_FFFF, 0, 0));
        add(mk(gthrbt_pkg::OP_KILL_IMM, 5, 0, 0, 1, 0));
        add(mk(gthrbt_pkg::OP_BIND, 31, 0, 0, 1, 1));
        add(mk(gthrbt_pkg::OP_LOCK_GUEST, 31, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_BIND, 0, 0, 0, 1, 0));
        add(mk(gthrbt_pkg::OP_LOCK_HOST, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_BIND, 31, 0, 0, 0, 1));
        add(mk(gthrbt_pkg::OP_UNLOCK_G, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_UNLOCK_H, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_SAVE, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_FLUSH_HOST, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_DISCARD, 31, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_RESTORE, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_DISCARD, 31, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_SET_IMM, 0, 0, 32'h0, 0, 0));
        add(mk(gthrbt_pkg::OP_SET_IMM, 31, 0, 32'h8000_0001, 0, 0));
        add(mk(gthrbt_pkg::OP_BIND, 7, 0, 0, 0, 1));
        add(mk(gthrbt_pkg::OP_FLUSH_ALL, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_STORE, 0, 0, 0, 0, 0));
        add(mk(gthrbt_pkg::OP_START, 0, 0, 0, 0, 0), 1'b1, closing(gthrbt_pkg::ST_OK));
        add(gthrbt_pkg::req_t'({4'd14, 5'd0, 4'd0, 32'd0, 2'b00}), 1'b1,
            closing(gthrbt_pkg::ST_OK));
        add(gthrbt_pkg::req_t'({4'd15, 5'd31, 4'd15, 32'hFFFF_FFFF, 2'b11}), 1'b1,
            closing(gthrbt_pkg::ST_OK));

        ord_set[0] = 64'hFEDC_BA98_7654_3210;  len_set[0] = gthrbt_pkg::OLEN_MAX;
        ord_set[1] = {$urandom, $urandom};     len_set[1] = 1;
        ord_set[2] = '1;                       len_set[2] = gthrbt_pkg::OLEN_MAX;
        ord_set[3] = {$urandom, $urandom};     len_set[3] = $urandom_range(16, 1);
        ord_set[4] = 64'h0123_4567_89AB_CDEF;  len_set[4] = 4;
        ord_set[5] = {$urandom, $urandom};     len_set[5] = $urandom_range(16, 1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // sender waits for every outstanding response before reconfiguring
            drain();
            write_cfg(gthrbt_pkg::CFG_ALLOC_ORDER, ord_set[ph]);
            write_cfg(gthrbt_pkg::CFG_ORDER_LEN, gthrbt_pkg::ORDER_W'(len_set[ph]));
            case (ph % 3)
                0: begin send_idle_pct = 33; stall_pct = 52; end
                1: begin send_idle_pct = 52; stall_pct = 33; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            repeat (PER_PHASE)
                send(rand_req());
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: guest_to_host_register_binding_table.f
rtl/gthrbt_pkg.sv
rtl/guest_to_host_register_binding_table.sv
sim/guest_to_host_register_binding_table_tb.sv
